FILE: hw/rtl/frs_pkg.sv
`default_nettype none
package frs_pkg;

   localparam int unsigned TimeW  = 32;
   localparam int unsigned RateW  = 32;
   localparam int unsigned ZoomW  = 24;
   localparam int unsigned DivNW  = 48;
   localparam int unsigned DivDW  = 32;
   localparam int unsigned SqrtW  = 64;
   localparam int unsigned RootW  = 32;
   localparam int unsigned CsrIdxW = 3;
   localparam int unsigned CsrDatW = 27;

   localparam logic [ZoomW-1:0] ZoomOne     = 24'd65536;
   localparam logic [ZoomW-1:0] ZoomMax     = 24'hFFFFFF;
   localparam logic [RateW-1:0] RateReset   = 32'd655360;
   localparam logic [TimeW-1:0] SpanStartRst = 32'hFFFFFFFF;
   localparam logic [DivNW-1:0] RateNumer   = 48'd1000 << 24;
   localparam logic [DivNW-1:0] MinNumer    = 48'd128 << 16;

   localparam logic OpRecord = 1'b0;
   localparam logic OpUpdate = 1'b1;

   localparam logic [2:0] KindTransmit = 3'd4;
   localparam logic [2:0] KindLastAlways = 3'd3;

   localparam logic [CsrIdxW-1:0] RegTargetRate    = 3'd0;
   localparam logic [CsrIdxW-1:0] RegDamping       = 3'd1;
   localparam logic [CsrIdxW-1:0] RegParentWidth   = 3'd2;
   localparam logic [CsrIdxW-1:0] RegParentHeight  = 3'd3;
   localparam logic [CsrIdxW-1:0] RegChannelWidth  = 3'd4;
   localparam logic [CsrIdxW-1:0] RegChannelHeight = 3'd5;
   localparam logic [CsrIdxW-1:0] RegCountTransmit = 3'd6;

   typedef struct packed {
      logic [26:0] target_rate;
      logic [16:0] damping;
      logic [14:0] parent_width;
      logic [14:0] parent_height;
      logic [14:0] channel_width;
      logic [14:0] channel_height;
      logic        count_transmit;
   } cfg_type;

   typedef struct packed {
      logic             is_update;
      logic             frozen;
      logic [TimeW-1:0] span;
   } cmd_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_RATE,
      ST_RATIO,
      ST_ROOT,
      ST_FACTOR,
      ST_MUL,
      ST_LO,
      ST_HI,
      ST_HI2
   } state_type;

endpackage
`default_nettype wire

FILE: hw/rtl/frame_rate_resolution_scaler.sv
// Dynamic resolution controller. Timing records of a frame stream in on req_ and are folded
// into a frame span at one per cycle while the queue has room; a closing record whose span
// is positive, and every zoom update request, is queued (QUEUE_DEPTH entries) for the back
// end. The back end runs one command at a time on a shared one-bit-per-cycle divider and a
// two-bit-per-cycle square root: a rate measurement uses one divide, an adjusting update
// four divides, a root and two multiply steps; a frozen update needs neither. The result
// register holds a result until rsp_tready; while it waits the back end takes no new
// command, and the front keeps accepting until the queue is full.
`default_nettype none
module frame_rate_resolution_scaler #(
   parameter int unsigned QUEUE_DEPTH = 4
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [71:0] req_tdata,  // start_time, end_time, frozen, zero pad
   input  wire logic [3:0]  req_tuser,  // opcode, stage_kind
   input  wire logic        req_tlast,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [31:0]      rsp_tdata,  // zoom, changed, zero pad
   input  wire logic        csr_we,
   input  wire logic [frs_pkg::CsrIdxW-1:0] csr_index,
   input  wire logic [frs_pkg::CsrDatW-1:0] csr_wdata
);

   frs_pkg::cfg_type cfg_ff, cfg_in;
   logic cmd_valid, cmd_pop, changed;
   frs_pkg::cmd_type cmd;
   logic [frs_pkg::ZoomW-1:0] zoom;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            frs_pkg::RegTargetRate:    cfg_in.target_rate    = csr_wdata[26:0];
            frs_pkg::RegDamping:       cfg_in.damping        = csr_wdata[16:0];
            frs_pkg::RegParentWidth:   cfg_in.parent_width   = csr_wdata[14:0];
            frs_pkg::RegParentHeight:  cfg_in.parent_height  = csr_wdata[14:0];
            frs_pkg::RegChannelWidth:  cfg_in.channel_width  = csr_wdata[14:0];
            frs_pkg::RegChannelHeight: cfg_in.channel_height = csr_wdata[14:0];
            frs_pkg::RegCountTransmit: cfg_in.count_transmit = csr_wdata[0];
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.target_rate    <= 27'd655360;
         cfg_ff.damping        <= 17'd32768;
         cfg_ff.parent_width   <= 15'd1024;
         cfg_ff.parent_height  <= 15'd768;
         cfg_ff.channel_width  <= 15'd1024;
         cfg_ff.channel_height <= 15'd768;
         cfg_ff.count_transmit <= 1'b1;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   frs_front #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_front (
      .clock          (clock),
      .reset          (reset),
      .in_valid       (req_tvalid),
      .in_ready       (req_tready),
      .opcode         (req_tuser[0]),
      .stage_kind     (req_tuser[3:1]),
      .start_time     (req_tdata[31:0]),
      .end_time       (req_tdata[63:32]),
      .last_record    (req_tlast),
      .frozen         (req_tdata[64]),
      .count_transmit (cfg_ff.count_transmit),
      .cmd_valid      (cmd_valid),
      .cmd            (cmd),
      .cmd_pop        (cmd_pop)
   );

   frs_back u_back (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg_ff),
      .cmd_valid   (cmd_valid),
      .cmd         (cmd),
      .cmd_pop     (cmd_pop),
      .out_valid   (rsp_tvalid),
      .out_ready   (rsp_tready),
      .out_zoom    (zoom),
      .out_changed (changed)
   );

   assign rsp_tdata = {7'd0, changed, zoom};

endmodule
`default_nettype wire

FILE: hw/rtl/frs_front.sv
`default_nettype none
module frs_front #(
   parameter int unsigned QUEUE_DEPTH = 4
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                in_valid,
   output logic                     in_ready,
   input  wire logic                opcode,
   input  wire logic [2:0]          stage_kind,
   input  wire logic [31:0]         start_time,
   input  wire logic [31:0]         end_time,
   input  wire logic                last_record,
   input  wire logic                frozen,
   input  wire logic                count_transmit,
   output logic                     cmd_valid,
   output frs_pkg::cmd_type         cmd,
   input  wire logic                cmd_pop
);

   localparam int unsigned PtrW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int unsigned CntW = $clog2(QUEUE_DEPTH + 1);
   localparam logic [PtrW-1:0] PtrLast = PtrW'(QUEUE_DEPTH - 1);
   localparam logic [CntW-1:0] CntFull = CntW'(QUEUE_DEPTH);

   frs_pkg::cmd_type queue_ff [QUEUE_DEPTH];
   logic [PtrW-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0] count_ff, count_in;
   logic [31:0] start_ff, start_in, end_ff, end_in;
   logic seen_ff, seen_in;

   logic accept, counted, push, pop;
   logic [31:0] start_new, end_new;
   logic seen_new;
   frs_pkg::cmd_type push_cmd;

   assign in_ready  = (count_ff != CntFull);
   assign cmd_valid = (count_ff != '0);
   assign cmd       = queue_ff[rd_ptr_ff];
   assign accept    = in_valid && in_ready;
   assign pop       = cmd_pop && cmd_valid;

   always_comb begin
      counted   = (stage_kind <= frs_pkg::KindLastAlways) ||
                  ((stage_kind == frs_pkg::KindTransmit) && count_transmit);
      start_new = start_ff;
      end_new   = end_ff;
      seen_new  = seen_ff;
      if (counted) begin
         if (start_time < start_ff) start_new = start_time;
         if (end_time > end_ff) end_new = end_time;
         seen_new = 1'b1;
      end
      push_cmd.is_update = (opcode == frs_pkg::OpUpdate);
      push_cmd.frozen    = frozen;
      push_cmd.span      = end_new - start_new;
      push     = 1'b0;
      start_in = start_ff;
      end_in   = end_ff;
      seen_in  = seen_ff;
      if (accept) begin
         if (opcode == frs_pkg::OpUpdate) begin
            push = 1'b1;
         end else if (last_record) begin
            push     = seen_new && (end_new > start_new);
            start_in = frs_pkg::SpanStartRst;
            end_in   = '0;
            seen_in  = 1'b0;
         end else begin
            start_in = start_new;
            end_in   = end_new;
            seen_in  = seen_new;
         end
      end
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (push) wr_ptr_in = (wr_ptr_ff == PtrLast) ? '0 : wr_ptr_ff + 1'b1;
      if (pop) rd_ptr_in = (rd_ptr_ff == PtrLast) ? '0 : rd_ptr_ff + 1'b1;
      count_in = count_ff;
      if (push && !pop) count_in = count_ff + 1'b1;
      else if (pop && !push) count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
         start_ff  <= frs_pkg::SpanStartRst;
         end_ff    <= '0;
         seen_ff   <= 1'b0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
         start_ff  <= start_in;
         end_ff    <= end_in;
         seen_ff   <= seen_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) queue_ff[wr_ptr_ff] <= push_cmd;
   end

endmodule
`default_nettype wire

FILE: hw/rtl/frs_div.sv
`default_nettype none
module frs_div (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      start,
   input  wire logic [frs_pkg::DivNW-1:0] dividend,
   input  wire logic [frs_pkg::DivDW-1:0] divisor,
   output logic                           done,
   output logic [frs_pkg::DivNW-1:0]      quotient
);

   localparam int unsigned NW = frs_pkg::DivNW;
   localparam int unsigned DW = frs_pkg::DivDW;
   localparam int unsigned CW = $clog2(NW + 1);

   logic [CW-1:0] cnt_ff, cnt_in;
   logic done_ff, done_in;
   logic [DW-1:0] rem_ff, rem_in, den_ff, den_in;
   logic [NW-1:0] quo_ff, quo_in;
   logic [DW:0] shifted, diff;

   assign done     = done_ff;
   assign quotient = quo_ff;

   always_comb begin
      shifted = {rem_ff, quo_ff[NW-1]};
      diff    = shifted - {1'b0, den_ff};
      cnt_in  = cnt_ff;
      done_in = 1'b0;
      rem_in  = rem_ff;
      den_in  = den_ff;
      quo_in  = quo_ff;
      if (start) begin
         cnt_in = CW'(NW);
         rem_in = '0;
         den_in = divisor;
         quo_in = dividend;
      end else if (cnt_ff != '0) begin
         cnt_in  = cnt_ff - 1'b1;
         done_in = (cnt_ff == CW'(1));
         if (shifted >= {1'b0, den_ff}) begin
            rem_in = diff[DW-1:0];
            quo_in = {quo_ff[NW-2:0], 1'b1};
         end else begin
            rem_in = shifted[DW-1:0];
            quo_in = {quo_ff[NW-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      den_ff <= den_in;
      quo_ff <= quo_in;
   end

endmodule
`default_nettype wire

FILE: hw/rtl/frs_sqrt.sv
`default_nettype none
module frs_sqrt (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      start,
   input  wire logic [frs_pkg::SqrtW-1:0] radicand,
   output logic                           done,
   output logic [frs_pkg::RootW-1:0]      root
);

   localparam int unsigned VW = frs_pkg::SqrtW;
   localparam int unsigned RW = frs_pkg::RootW;
   localparam int unsigned CW = $clog2(RW + 1);

   logic [CW-1:0] cnt_ff, cnt_in;
   logic done_ff, done_in;
   logic [VW-1:0] val_ff, val_in;
   logic [RW+1:0] rem_ff, rem_in;
   logic [RW-1:0] root_ff, root_in;
   logic [RW+3:0] rem_t, trial, rem_sub;

   assign done = done_ff;
   assign root = root_ff;

   always_comb begin
      rem_t   = {rem_ff, val_ff[VW-1:VW-2]};
      trial   = {2'b00, root_ff, 2'b01};
      rem_sub = rem_t - trial;
      cnt_in  = cnt_ff;
      done_in = 1'b0;
      val_in  = val_ff;
      rem_in  = rem_ff;
      root_in = root_ff;
      if (start) begin
         cnt_in  = CW'(RW);
         val_in  = radicand;
         rem_in  = '0;
         root_in = '0;
      end else if (cnt_ff != '0) begin
         cnt_in  = cnt_ff - 1'b1;
         done_in = (cnt_ff == CW'(1));
         val_in  = {val_ff[VW-3:0], 2'b00};
         if (rem_t >= trial) begin
            rem_in  = rem_sub[RW+1:0];
            root_in = {root_ff[RW-2:0], 1'b1};
         end else begin
            rem_in  = rem_t[RW+1:0];
            root_in = {root_ff[RW-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      val_ff  <= val_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
   end

endmodule
`default_nettype wire

FILE: hw/rtl/frs_back.sv
`default_nettype none
module frs_back (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire frs_pkg::cfg_type          cfg,
   input  wire logic                      cmd_valid,
   input  wire frs_pkg::cmd_type          cmd,
   output logic                           cmd_pop,
   output logic                           out_valid,
   input  wire logic                      out_ready,
   output logic [frs_pkg::ZoomW-1:0]      out_zoom,
   output logic                           out_changed
);

   localparam int unsigned ZW = frs_pkg::ZoomW;

   frs_pkg::state_type st_ff, st_in;
   logic [31:0] meas_ff, meas_in;
   logic ready_ff, ready_in;
   logic [ZW-1:0] zoom_ff, zoom_in;
   logic [31:0] root_ff, root_in;
   logic [49:0] mag_ff, mag_in;
   logic neg_ff, neg_in;
   logic [ZW-1:0] zprod_ff, zprod_in, lo_ff, lo_in, hi_ff, hi_in;
   logic oval_ff, oval_in, ochg_ff, ochg_in;
   logic [ZW-1:0] ozoom_ff, ozoom_in;

   logic div_start, div_done, sqrt_start, sqrt_done;
   logic [frs_pkg::DivNW-1:0] div_n, div_q;
   logic [frs_pkg::DivDW-1:0] div_d;
   logic [frs_pkg::SqrtW-1:0] sqrt_v;
   logic [31:0] sqrt_r;

   logic out_free;
   logic [26:0] tgt;
   logic [14:0] pw, ph, pmin;
   logic [46:0] ratio;
   logic [32:0] diff;
   logic [33:0] mag_hi, factor;
   logic [57:0] zmul;
   logic [ZW-1:0] q_sat, hmin, zfin;

   frs_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_n),
      .divisor  (div_d),
      .done     (div_done),
      .quotient (div_q)
   );

   frs_sqrt u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (sqrt_start),
      .radicand (sqrt_v),
      .done     (sqrt_done),
      .root     (sqrt_r)
   );

   assign out_valid   = oval_ff;
   assign out_zoom    = ozoom_ff;
   assign out_changed = ochg_ff;

   always_comb begin
      out_free = !oval_ff || out_ready;
      tgt  = (cfg.target_rate == '0) ? 27'd1 : cfg.target_rate;
      pw   = (cfg.parent_width == '0) ? 15'd1 : cfg.parent_width;
      ph   = (cfg.parent_height == '0) ? 15'd1 : cfg.parent_height;
      pmin = (pw < ph) ? pw : ph;
      ratio  = div_q[47] ? {47{1'b1}} : div_q[46:0];
      q_sat  = (div_q > 48'(frs_pkg::ZoomMax)) ? frs_pkg::ZoomMax : div_q[ZW-1:0];
      diff   = (root_ff >= 32'd65536) ? 33'(root_ff) - 33'd65536
                                      : 33'd65536 - 33'(root_ff);
      mag_hi = mag_ff[49:16];
      if (neg_ff) factor = (mag_hi > 34'd65536) ? '0 : 34'd65536 - mag_hi;
      else factor = 34'd65536 + mag_hi;
      zmul = 58'(zoom_ff) * 58'(factor);
      hmin = (q_sat < hi_ff) ? q_sat : hi_ff;
      zfin = (zprod_ff < lo_ff) ? lo_ff : zprod_ff;
      if (zfin > hmin) zfin = hmin;

      st_in    = st_ff;
      meas_in  = meas_ff;
      ready_in = ready_ff;
      zoom_in  = zoom_ff;
      root_in  = root_ff;
      mag_in   = mag_ff;
      neg_in   = neg_ff;
      zprod_in = zprod_ff;
      lo_in    = lo_ff;
      hi_in    = hi_ff;
      oval_in  = oval_ff && !out_ready;
      ozoom_in = ozoom_ff;
      ochg_in  = ochg_ff;
      cmd_pop    = 1'b0;
      div_start  = 1'b0;
      div_n      = '0;
      div_d      = '0;
      sqrt_start = 1'b0;
      sqrt_v     = {1'b0, ratio, 16'd0};

      case (st_ff)
         frs_pkg::ST_IDLE: begin
            if (cmd_valid && out_free) begin
               cmd_pop = 1'b1;
               if (!cmd.is_update) begin
                  div_start = 1'b1;
                  div_n     = frs_pkg::RateNumer;
                  div_d     = cmd.span;
                  st_in     = frs_pkg::ST_RATE;
               end else if (cmd.frozen) begin
                  zoom_in  = frs_pkg::ZoomOne;
                  oval_in  = 1'b1;
                  ozoom_in = frs_pkg::ZoomOne;
                  ochg_in  = (zoom_ff != frs_pkg::ZoomOne);
               end else if (ready_ff) begin
                  ready_in  = 1'b0;
                  div_start = 1'b1;
                  div_n     = {meas_ff, 16'd0};
                  div_d     = 32'(tgt);
                  st_in     = frs_pkg::ST_RATIO;
               end
            end
         end
         frs_pkg::ST_RATE: begin
            if (div_done) begin
               meas_in  = (div_q[47:32] != '0) ? 32'hFFFFFFFF : div_q[31:0];
               ready_in = 1'b1;
               st_in    = frs_pkg::ST_IDLE;
            end
         end
         frs_pkg::ST_RATIO: begin
            if (div_done) begin
               sqrt_start = 1'b1;
               st_in      = frs_pkg::ST_ROOT;
            end
         end
         frs_pkg::ST_ROOT: begin
            if (sqrt_done) begin
               root_in = sqrt_r;
               st_in   = frs_pkg::ST_FACTOR;
            end
         end
         frs_pkg::ST_FACTOR: begin
            neg_in = (root_ff < 32'd65536);
            mag_in = 50'(diff) * 50'(cfg.damping);
            st_in  = frs_pkg::ST_MUL;
         end
         frs_pkg::ST_MUL: begin
            zprod_in  = (zmul[57:40] != '0) ? frs_pkg::ZoomMax : zmul[39:16];
            div_start = 1'b1;
            div_n     = frs_pkg::MinNumer;
            div_d     = 32'(pmin);
            st_in     = frs_pkg::ST_LO;
         end
         frs_pkg::ST_LO: begin
            if (div_done) begin
               lo_in     = q_sat;
               div_start = 1'b1;
               div_n     = {17'd0, cfg.channel_width, 16'd0};
               div_d     = 32'(pw);
               st_in     = frs_pkg::ST_HI;
            end
         end
         frs_pkg::ST_HI: begin
            if (div_done) begin
               hi_in     = q_sat;
               div_start = 1'b1;
               div_n     = {17'd0, cfg.channel_height, 16'd0};
               div_d     = 32'(ph);
               st_in     = frs_pkg::ST_HI2;
            end
         end
         frs_pkg::ST_HI2: begin
            if (div_done) begin
               zoom_in  = zfin;
               oval_in  = 1'b1;
               ozoom_in = zfin;
               ochg_in  = (zfin != zoom_ff);
               st_in    = frs_pkg::ST_IDLE;
            end
         end
         default: st_in = frs_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff    <= frs_pkg::ST_IDLE;
         meas_ff  <= frs_pkg::RateReset;
         ready_ff <= 1'b0;
         zoom_ff  <= frs_pkg::ZoomOne;
         oval_ff  <= 1'b0;
      end else begin
         st_ff    <= st_in;
         meas_ff  <= meas_in;
         ready_ff <= ready_in;
         zoom_ff  <= zoom_in;
         oval_ff  <= oval_in;
      end
   end

   always_ff @(posedge clock) begin
      root_ff  <= root_in;
      mag_ff   <= mag_in;
      neg_ff   <= neg_in;
      zprod_ff <= zprod_in;
      lo_ff    <= lo_in;
      hi_ff    <= hi_in;
      ozoom_ff <= ozoom_in;
      ochg_ff  <= ochg_in;
   end

endmodule
`default_nettype wire

FILE: hw/rtl/frs_checker.sv
`default_nettype none
module frs_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [31:0] rsp_tdata
);

   a_idle_after_reset: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid right after reset");

   a_hold_valid: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("result dropped while stalled");

   a_hold_data: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> $stable(rsp_tdata))
      else $error("result changed while stalled");

   a_pad_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[31:25] == 7'd0)
      else $error("result pad bits set");

endmodule

bind frame_rate_resolution_scaler frs_checker u_frs_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
`default_nettype wire

FILE: bench/tb_top.sv
`default_nettype none
module tb_top;

   typedef struct {
      logic        opcode;
      logic [2:0]  kind;
      logic [31:0] t0;
      logic [31:0] t1;
      logic        last;
      logic        frozen;
      logic        has_exp;
      logic [23:0] exp_zoom;
      logic        exp_changed;
   } row_type;

   typedef struct {
      logic [23:0] zoom;
      logic        changed;
   } zoom_rsp_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [71:0] req_tdata = '0;
   logic [3:0]  req_tuser = '0;
   logic        req_tlast = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;
   logic        csr_we = 1'b0;
   logic [frs_pkg::CsrIdxW-1:0] csr_index = '0;
   logic [frs_pkg::CsrDatW-1:0] csr_wdata = '0;

   // model copy of configuration and state
   logic [26:0] m_target;
   logic [16:0] m_damping;
   logic [14:0] m_pw, m_ph, m_cw, m_ch;
   logic        m_count_tx;
   logic [31:0] m_span_start, m_span_end, m_rate;
   logic        m_seen, m_ready;
   logic [23:0] m_zoom;

   zoom_rsp_type pending_zooms[$];
   int errors = 0;
   int idle_pct = 22;

   frame_rate_resolution_scaler u_top (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .req_tuser(req_tuser), .req_tlast(req_tlast),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic logic [63:0] isqrt(input logic [63:0] v);
      logic [63:0] r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > v) b = b >> 2;
      while (b != 0) begin
         if (v >= r + b) begin
            v = v - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return r;
   endfunction

   function automatic logic [63:0] sat_zoom(input logic [63:0] v);
      return (v > 64'hFFFFFF) ? 64'hFFFFFF : v;
   endfunction

   function automatic logic [23:0] next_zoom();
      logic [63:0] tgt, pw, ph, ratio, root, z, lo, hi, hi2;
      longint signed fac;
      tgt = (m_target == 0) ? 64'd1 : 64'(m_target);
      pw = (m_pw == 0) ? 64'd1 : 64'(m_pw);
      ph = (m_ph == 0) ? 64'd1 : 64'(m_ph);
      ratio = (64'(m_rate) << 16) / tgt;
      if (ratio > ((64'd1 << 47) - 1)) ratio = (64'd1 << 47) - 1;
      root = isqrt(ratio << 16);
      fac = 65536 + ((longint'(root) - 65536) * longint'(m_damping)) / 65536;
      if (fac < 0) fac = 0;
      z = sat_zoom((64'(m_zoom) * 64'(fac)) >> 16);
      lo = (64'd128 << 16) / ((pw < ph) ? pw : ph);
      hi = sat_zoom((64'(m_cw) << 16) / pw);
      hi2 = sat_zoom((64'(m_ch) << 16) / ph);
      if (hi2 < hi) hi = hi2;
      if (z < lo) z = lo;
      if (z > hi) z = hi;
      return z[23:0];
   endfunction

   // advance the model by one item, queue a response if one results
   function automatic void predict_zoom(input row_type r);
      logic [63:0] rate;
      logic [23:0] old;
      zoom_rsp_type x;
      old = m_zoom;
      if (r.opcode == frs_pkg::OpRecord) begin
         if (r.kind <= frs_pkg::KindLastAlways ||
             (r.kind == frs_pkg::KindTransmit && m_count_tx)) begin
            if (r.t0 < m_span_start) m_span_start = r.t0;
            if (r.t1 > m_span_end) m_span_end = r.t1;
            m_seen = 1'b1;
         end
         if (r.last) begin
            if (m_seen && m_span_end > m_span_start) begin
               rate = (64'd1000 << 24) / 64'(m_span_end - m_span_start);
               m_rate = (rate > 64'hFFFFFFFF) ? 32'hFFFFFFFF : rate[31:0];
               m_ready = 1'b1;
            end
            m_span_start = frs_pkg::SpanStartRst;
            m_span_end = 0;
            m_seen = 1'b0;
         end
         return;
      end
      if (r.frozen) begin
         m_zoom = frs_pkg::ZoomOne;
      end else begin
         if (!m_ready) return;
         m_ready = 1'b0;
         m_zoom = next_zoom();
      end
      x.zoom = m_zoom;
      x.changed = (m_zoom != old);
      if (r.has_exp && x.zoom !== r.exp_zoom) begin
         $error("table zoom: expected %0d actual %0d", r.exp_zoom, x.zoom);
         errors++;
      end
      if (r.has_exp && x.changed !== r.exp_changed) begin
         $error("table changed: expected %0d actual %0d", r.exp_changed, x.changed);
         errors++;
      end
      pending_zooms.push_back(x);
   endfunction

   task automatic write_csr(input logic [frs_pkg::CsrIdxW-1:0] idx,
                            input logic [frs_pkg::CsrDatW-1:0] val);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      case (idx)
         frs_pkg::RegTargetRate:    m_target = val[26:0];
         frs_pkg::RegDamping:       m_damping = val[16:0];
         frs_pkg::RegParentWidth:   m_pw = val[14:0];
         frs_pkg::RegParentHeight:  m_ph = val[14:0];
         frs_pkg::RegChannelWidth:  m_cw = val[14:0];
         frs_pkg::RegChannelHeight: m_ch = val[14:0];
         frs_pkg::RegCountTransmit: m_count_tx = val[0];
         default: ;
      endcase
   endtask

   task automatic send_item(input row_type r);
      while (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {7'd0, r.frozen, r.t1, r.t0};
      req_tuser <= {r.kind, r.opcode};
      req_tlast <= r.last;
      do @(posedge clock); while (!req_tready);
      predict_zoom(r);
   endtask

   task automatic drain();
      int n;
      n = 0;
      req_tvalid <= 1'b0;
      while (pending_zooms.size() != 0) @(posedge clock);
      // a closing record can still be computing a rate
      while (n < 400) begin
         @(posedge clock);
         n++;
      end
   endtask

   function automatic row_type mk(input logic op, input logic [2:0] k, input logic [31:0] a,
                                  input logic [31:0] b, input logic l, input logic f);
      row_type r;
      r.opcode = op; r.kind = k; r.t0 = a; r.t1 = b; r.last = l; r.frozen = f;
      r.has_exp = 1'b0; r.exp_zoom = '0; r.exp_changed = 1'b0;
      return r;
   endfunction

   function automatic row_type mk_exp(input row_type r, input logic [23:0] z, input logic c);
      r.has_exp = 1'b1; r.exp_zoom = z; r.exp_changed = c;
      return r;
   endfunction

   function automatic row_type rand_item();
      logic [31:0] base;
      int p;
      p = $urandom_range(99);
      base = $urandom;
      if (p < 55)
         return mk(frs_pkg::OpRecord, 3'($urandom_range(7)), base,
                   base + $urandom_range(1 << $urandom_range(20)), 1'b0, 1'($urandom));
      if (p < 75)
         return mk(frs_pkg::OpRecord, 3'($urandom_range(7)), base,
                   base + $urandom_range(1 << $urandom_range(20)), 1'b1, 1'($urandom));
      if (p < 85)
         return mk(frs_pkg::OpRecord, 3'($urandom_range(7)), $urandom, $urandom,
                   1'($urandom), 1'($urandom));
      return mk(frs_pkg::OpUpdate, 3'($urandom_range(7)), $urandom, $urandom, 1'($urandom),
                ($urandom_range(9) == 0));
   endfunction

   // response checker
   always @(posedge clock) begin
      zoom_rsp_type e;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_zooms.size() == 0) begin
            $error("unexpected transfer: zoom %0d", rsp_tdata[23:0]);
            errors++;
         end else begin
            e = pending_zooms.pop_front();
            if (rsp_tdata[23:0] !== e.zoom) begin
               $error("zoom: expected %0d actual %0d", e.zoom, rsp_tdata[23:0]);
               errors++;
            end
            if (rsp_tdata[24] !== e.changed) begin
               $error("changed: expected %0d actual %0d", e.changed, rsp_tdata[24]);
               errors++;
            end
         end
      end
      if (idle_pct > 0) rsp_tready <= ($urandom_range(99) >= idle_pct);
      else rsp_tready <= 1'b1;
   end

   initial begin
      row_type tbl[$];
      row_type r;
      m_target = 27'd655360; m_damping = 17'd32768;
      m_pw = 15'd1024; m_ph = 15'd768; m_cw = 15'd1024; m_ch = 15'd768;
      m_count_tx = 1'b1;
      m_span_start = frs_pkg::SpanStartRst; m_span_end = 0; m_seen = 1'b0;
      m_rate = frs_pkg::RateReset; m_ready = 1'b0; m_zoom = frs_pkg::ZoomOne;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // update with nothing ready gives nothing; frozen gives one, unchanged
      tbl.push_back(mk(frs_pkg::OpUpdate, 3'd0, 32'd0, 32'd0, 1'b0, 1'b0));
      tbl.push_back(mk_exp(mk(frs_pkg::OpUpdate, 3'd7, 32'hFFFFFFFF, 32'hFFFFFFFF, 1'b1,
                              1'b1), frs_pkg::ZoomOne, 1'b0));
      // one frame over kinds 0 to 6, 100 ms span
      tbl.push_back(mk(frs_pkg::OpRecord, 3'd0, 32'd1000, 32'd2000, 1'b0, 1'b1));
      tbl.push_back(mk(frs_pkg::OpRecord, 3'd1, 32'd500, 32'd3000, 1'b0, 1'b0));
      tbl.push_back(mk(frs_pkg::OpRecord, 3'd2, 32'd600, 32'd4000, 1'b0, 1'b0));
      tbl.push_back(mk(frs_pkg::OpRecord, 3'd5, 32'd0, 32'hFFFFFFFF, 1'b0, 1'b0));
      tbl.push_back(mk(frs_pkg::OpRecord, 3'd6, 32'd0, 32'hFFFFFFFF, 1'b0, 1'b0));
      tbl.push_back(mk(frs_pkg::OpRecord, 3'd4, 32'd700, 32'd10000, 1'b0, 1'b0));
      tbl.push_back(mk(frs_pkg::OpRecord, 3'd3, 32'd800, 32'd26100, 1'b1, 1'b0));
      tbl.push_back(mk(frs_pkg::OpUpdate, 3'd0, 32'd0, 32'd0, 1'b0, 1'b0));
      // tiny span, extreme rate
      tbl.push_back(mk(frs_pkg::OpRecord, 3'd1, 32'hFFFFFFFE, 32'hFFFFFFFF, 1'b1, 1'b0));
      tbl.push_back(mk(frs_pkg::OpUpdate, 3'd0, 32'd0, 32'd0, 1'b0, 1'b0));
      // zero and negative spans and an uncounted kind leave ready clear
      tbl.push_back(mk(frs_pkg::OpRecord, 3'd2, 32'd50, 32'd50, 1'b1, 1'b0));
      tbl.push_back(mk(frs_pkg::OpRecord, 3'd7, 32'd0, 32'd100, 1'b1, 1'b0));
      tbl.push_back(mk(frs_pkg::OpRecord, 3'd1, 32'd90, 32'd10, 1'b1, 1'b0));
      tbl.push_back(mk(frs_pkg::OpUpdate, 3'd0, 32'd0, 32'd0, 1'b0, 1'b0));
      // huge span, low rate
      tbl.push_back(mk(frs_pkg::OpRecord, 3'd0, 32'd0, 32'hFFFFFFFF, 1'b1, 1'b0));
      tbl.push_back(mk(frs_pkg::OpUpdate, 3'd0, 32'd0, 32'd0, 1'b0, 1'b0));
      tbl.push_back(mk(frs_pkg::OpUpdate, 3'd0, 32'd0, 32'd0, 1'b0, 1'b1));
      foreach (tbl[i]) send_item(tbl[i]);
      drain();

      // setting sweep: reset values, extremes, zeros, unknown index, a typical setup, random values
      for (int ph = 0; ph < 8; ph++) begin
         case (ph)
            0: ;
            1: begin
               write_csr(frs_pkg::RegTargetRate, 27'd65536);
               write_csr(frs_pkg::RegDamping, 27'd65536);
               write_csr(frs_pkg::RegParentWidth, 27'd16384);
               write_csr(frs_pkg::RegParentHeight, 27'd16384);
               write_csr(frs_pkg::RegChannelWidth, 27'd16384);
               write_csr(frs_pkg::RegChannelHeight, 27'd1);
               write_csr(frs_pkg::RegCountTransmit, 27'd0);
            end
            2: begin
               write_csr(frs_pkg::RegTargetRate, 27'h7FFFFFF);
               write_csr(frs_pkg::RegDamping, 27'd0);
               write_csr(frs_pkg::RegParentWidth, 27'd1);
               write_csr(frs_pkg::RegParentHeight, 27'd1);
               write_csr(frs_pkg::RegChannelWidth, 27'h7FFF);
               write_csr(frs_pkg::RegChannelHeight, 27'h7FFF);
               write_csr(frs_pkg::RegCountTransmit, 27'd1);
            end
            3: begin
               write_csr(frs_pkg::RegTargetRate, 27'd0);
               write_csr(frs_pkg::RegDamping, 27'h1FFFF);
               write_csr(frs_pkg::RegParentWidth, 27'd0);
               write_csr(frs_pkg::RegParentHeight, 27'd0);
               write_csr(frs_pkg::RegChannelWidth, 27'd0);
               write_csr(frs_pkg::RegChannelHeight, 27'd5);
               write_csr(3'd7, 27'h5555555);
            end
            4: begin
               write_csr(frs_pkg::RegTargetRate, 27'd3932160);
               write_csr(frs_pkg::RegDamping, 27'd65536);
               write_csr(frs_pkg::RegParentWidth, 27'd1920);
               write_csr(frs_pkg::RegParentHeight, 27'd1080);
               write_csr(frs_pkg::RegChannelWidth, 27'd3840);
               write_csr(frs_pkg::RegChannelHeight, 27'd2160);
               write_csr(frs_pkg::RegCountTransmit, 27'd0);
            end
            default: begin
               write_csr(frs_pkg::RegTargetRate, 27'($urandom));
               write_csr(frs_pkg::RegDamping, 27'($urandom));
               write_csr(frs_pkg::RegParentWidth, 27'($urandom_range(1, 16384)));
               write_csr(frs_pkg::RegParentHeight, 27'($urandom_range(1, 16384)));
               write_csr(frs_pkg::RegChannelWidth, 27'($urandom_range(1, 16384)));
               write_csr(frs_pkg::RegChannelHeight, 27'($urandom_range(1, 16384)));
               write_csr(frs_pkg::RegCountTransmit, 27'($urandom));
            end
         endcase
         csr_we <= 1'b0;
         idle_pct = (ph == 5) ? 0 : 22;
         for (int i = 0; i < 235; i++) begin
            r = rand_item();
            send_item(r);
         end
         drain();
      end

      if (errors == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

   initial begin
      #20000000;
      $display("DONE: errors detected");
      $finish;
   end

endmodule
`default_nettype wire

FILE: filelist.f
hw/rtl/frs_pkg.sv
hw/rtl/frs_front.sv
hw/rtl/frs_div.sv
hw/rtl/frs_sqrt.sv
hw/rtl/frs_back.sv
hw/rtl/frame_rate_resolution_scaler.sv
hw/rtl/frs_checker.sv
bench/tb_top.sv
